/* src/crt_pkg.sv */
// Shared types and constants for the CSV record tokenizer.
package crt_pkg;

  localparam int MaxResults = 6;
  localparam int ResCntW    = $clog2(MaxResults + 1);

  localparam logic [7:0] QuoteByte  = 8'h22;
  localparam logic [7:0] CrByte     = 8'h0d;
  localparam logic [7:0] LfByte     = 8'h0a;
  localparam logic [7:0] Bom0Byte   = 8'hef;
  localparam logic [7:0] Bom1Byte   = 8'hbb;
  localparam logic [7:0] Bom2Byte   = 8'hbf;
  localparam logic [7:0] DelimReset = 8'd44;

  // Register indexes on the configuration write port.
  localparam logic CfgIdxDelim   = 1'b0;
  localparam logic CfgIdxSkipBom = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_FIELD_END,
    KIND_RECORD_END,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    logic [1:0] bom_cnt;
    logic       started;
    logic       in_rec;
    logic       parity;
    logic       at_start;
    logic       quoted;
    logic [7:0] held_byte;
    logic       held_valid;
    logic       pend_quote;
    logic       after_delim;
  } state_t;

  localparam state_t StateReset = '{
    bom_cnt:     2'd0,
    started:     1'b0,
    in_rec:      1'b0,
    parity:      1'b0,
    at_start:    1'b1,
    quoted:      1'b0,
    held_byte:   8'h00,
    held_valid:  1'b0,
    pend_quote:  1'b0,
    after_delim: 1'b0
  };

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } result_t;

  typedef struct packed {
    result_t [MaxResults-1:0] r;
    logic    [ResCntW-1:0]    cnt;
  } res_list_t;

endpackage

/* src/crt_step.sv */
// Next-state and result-list logic for one input byte or end-of-stream marker.
module crt_step (
  input  crt_pkg::state_t    state_i,
  input  logic [7:0]         byte_i,
  input  logic               eos_i,
  input  logic [7:0]         delim_i,
  input  logic               skip_bom_i,
  output crt_pkg::state_t    state_o,
  output crt_pkg::res_list_t list_o
);

  typedef struct packed {
    crt_pkg::state_t    s;
    crt_pkg::res_list_t l;
  } ctx_t;

  function automatic ctx_t emit(ctx_t c, crt_pkg::kind_e k, logic [7:0] v);
    ctx_t n;
    n = c;
    if (n.l.cnt < crt_pkg::ResCntW'(crt_pkg::MaxResults)) begin
      n.l.r[n.l.cnt].kind  = k;
      n.l.r[n.l.cnt].value = (k == crt_pkg::KIND_BYTE) ? v : 8'h00;
      n.l.cnt = n.l.cnt + 1'b1;
    end
    return n;
  endfunction

  // Doubled quotes collapse to one: a quote is held until the next byte shows
  // whether it pairs up.
  function automatic ctx_t collapse(ctx_t c, logic [7:0] b);
    ctx_t n;
    n = c;
    if (b == crt_pkg::QuoteByte) begin
      if (n.s.pend_quote) begin
        n = emit(n, crt_pkg::KIND_BYTE, crt_pkg::QuoteByte);
        n.s.pend_quote = 1'b0;
      end else begin
        n.s.pend_quote = 1'b1;
      end
    end else begin
      if (n.s.pend_quote) begin
        n = emit(n, crt_pkg::KIND_BYTE, crt_pkg::QuoteByte);
        n.s.pend_quote = 1'b0;
      end
      n = emit(n, crt_pkg::KIND_BYTE, b);
    end
    return n;
  endfunction

  // Quoted fields run one byte behind so that the closing quote can be dropped.
  function automatic ctx_t content(ctx_t c, logic [7:0] b);
    ctx_t n;
    n = c;
    if (n.s.quoted) begin
      if (n.s.held_valid) begin
        n = collapse(n, n.s.held_byte);
      end
      n.s.held_byte  = b;
      n.s.held_valid = 1'b1;
    end else begin
      n = collapse(n, b);
    end
    return n;
  endfunction

  function automatic crt_pkg::state_t reset_field(crt_pkg::state_t s);
    crt_pkg::state_t n;
    n            = s;
    n.at_start   = 1'b1;
    n.quoted     = 1'b0;
    n.parity     = 1'b0;
    n.held_byte  = 8'h00;
    n.held_valid = 1'b0;
    n.pend_quote = 1'b0;
    return n;
  endfunction

  function automatic ctx_t close_field(ctx_t c, logic keep);
    ctx_t n;
    n = c;
    n.s.held_valid = 1'b0;
    n.s.held_byte  = 8'h00;
    if (n.s.pend_quote) begin
      n = emit(n, crt_pkg::KIND_BYTE, crt_pkg::QuoteByte);
      n.s.pend_quote = 1'b0;
    end
    if (keep) begin
      n = emit(n, crt_pkg::KIND_FIELD_END, 8'h00);
    end
    return n;
  endfunction

  function automatic ctx_t data_byte(ctx_t c, logic [7:0] b, logic [7:0] delim);
    ctx_t n;
    logic eol;
    logic skip;
    n    = c;
    skip = 1'b0;
    eol  = (b == crt_pkg::CrByte) || (b == crt_pkg::LfByte);
    if (!n.s.in_rec) begin
      if (eol) begin
        skip = 1'b1;
      end else begin
        n.s.in_rec      = 1'b1;
        n.s.after_delim = 1'b0;
        n.s             = reset_field(n.s);
      end
    end
    if (!skip) begin
      if (eol && !n.s.parity) begin
        n = close_field(n, !(n.s.at_start && n.s.after_delim));
        n = emit(n, crt_pkg::KIND_RECORD_END, 8'h00);
        n.s.in_rec      = 1'b0;
        n.s.after_delim = 1'b0;
        n.s             = reset_field(n.s);
      end else if (b == crt_pkg::QuoteByte) begin
        n.s.parity = !n.s.parity;
        if (n.s.at_start) begin
          n.s.quoted   = 1'b1;
          n.s.at_start = 1'b0;
        end else begin
          n = content(n, b);
        end
      end else if (b == delim && !n.s.parity) begin
        n = close_field(n, 1'b1);
        n.s             = reset_field(n.s);
        n.s.after_delim = 1'b1;
      end else begin
        n.s.at_start = 1'b0;
        n = content(n, b);
      end
    end
    return n;
  endfunction

  // A partial byte order mark is fed through as ordinary data.
  function automatic ctx_t replay_bom(ctx_t c, logic [7:0] delim);
    ctx_t n;
    n = c;
    if (n.s.bom_cnt != 2'd0) begin
      n = data_byte(n, crt_pkg::Bom0Byte, delim);
    end
    if (n.s.bom_cnt >= 2'd2) begin
      n = data_byte(n, crt_pkg::Bom1Byte, delim);
    end
    n.s.bom_cnt = 2'd0;
    n.s.started = 1'b1;
    return n;
  endfunction

  function automatic logic [7:0] bom_byte(logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = crt_pkg::Bom0Byte;
      2'd1:    r = crt_pkg::Bom1Byte;
      default: r = crt_pkg::Bom2Byte;
    endcase
    return r;
  endfunction

  ctx_t c;

  always_comb begin
    c.s     = state_i;
    c.l     = '0;
    if (eos_i) begin
      if (!c.s.started) begin
        c = replay_bom(c, delim_i);
      end
      if (c.s.in_rec) begin
        if (c.s.parity) begin
          c.s.held_valid = 1'b0;
          c.s.pend_quote = 1'b0;
          c = emit(c, crt_pkg::KIND_ERROR, 8'h00);
        end else begin
          c = close_field(c, !(c.s.at_start && c.s.after_delim));
        end
        c = emit(c, crt_pkg::KIND_RECORD_END, 8'h00);
      end
      c.s = crt_pkg::StateReset;
    end else begin
      if (!c.s.started && skip_bom_i && (c.s.bom_cnt != 2'd3) &&
          (byte_i == bom_byte(c.s.bom_cnt))) begin
        if (c.s.bom_cnt == 2'd2) begin
          c.s.bom_cnt = 2'd0;
          c.s.started = 1'b1;
        end else begin
          c.s.bom_cnt = c.s.bom_cnt + 2'd1;
        end
      end else begin
        if (!c.s.started) begin
          c = replay_bom(c, delim_i);
        end
        c = data_byte(c, byte_i, delim_i);
      end
    end
  end

  assign state_o = c.s;
  assign list_o  = c.l;

endmodule

/* src/crt_out_buf.sv */
// Result register for one byte's result list; one entry a cycle while tready is high.
module crt_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  crt_pkg::res_list_t list_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,
  output logic [1:0]         m_axis_tuser,
  output logic               m_axis_tlast
);

  crt_pkg::result_t [crt_pkg::MaxResults-1:0] list_q;
  logic [crt_pkg::ResCntW-1:0] cnt_q, cnt_d;
  logic [crt_pkg::ResCntW-1:0] idx_q, idx_d;
  crt_pkg::result_t cur;
  logic is_last;

  assign cur           = list_q[idx_q];
  assign is_last       = (idx_q == (cnt_q - 1'b1));
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = cur.value;
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = is_last;
  assign free_o        = (cnt_q == '0) || (m_axis_tready && is_last);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = list_i.cnt;
      idx_d = '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (is_last) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      list_q <= list_i.r;
    end
  end

endmodule

/* src/csv_record_tokenizer_core.sv */
// Top level of the streaming CSV record tokenizer.
//
// The block parses a byte stream one byte per transfer on the slave side
// (tuser high marks end of stream) and emits field bytes, field ends, record
// ends and an unterminated-quote error on the master side, one result per
// transfer, with tlast on the final result caused by an input byte. An
// accepted byte sits in an input register; the parse step, a short piece of
// logic over the tokenizer state, then loads the result register with the
// byte's whole result list (zero to six entries) at once and updates the
// state. A new byte is taken every cycle while each byte yields at most one
// result and the output accepts every result; a byte with several results
// keeps the next byte waiting in the input register until they have drained
// through the single result port. Bytes with no result (BOM bytes, empty
// lines, an opening quote, held quoted bytes) do not hold the input. The
// user must write the delimiter and BOM skip registers through the plain
// write port while the block is idle; the block does not enforce this.
module csv_record_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port: index 0 delimiter, index 1 BOM skip enable.
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  // Input stream.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] end_of_stream
  // Result stream.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_value
  output logic [1:0] m_axis_tuser,   // [1:0] out_kind
  output logic       m_axis_tlast    // last_of_run
);

  // Configuration registers.
  logic [7:0] delim_q;
  logic       skip_bom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= crt_pkg::DelimReset;
      skip_bom_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        crt_pkg::CfgIdxDelim:   delim_q    <= cfg_data_i;
        crt_pkg::CfgIdxSkipBom: skip_bom_q <= cfg_data_i[0];
        default:                ;
      endcase
    end
  end

  // Input register. It takes a new byte when empty, even while the result
  // register drains older results, or as the previous byte moves to it.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;
  logic       out_free;
  logic       advance;

  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eos_q  <= s_axis_tuser;
    end
  end

  // Tokenizer state advances only when a byte is committed to the results.
  crt_pkg::state_t    state_q, state_d;
  crt_pkg::res_list_t step_list;

  crt_step u_step (
    .state_i    (state_q),
    .byte_i     (in_byte_q),
    .eos_i      (in_eos_q),
    .delim_i    (delim_q),
    .skip_bom_i (skip_bom_q),
    .state_o    (state_d),
    .list_o     (step_list)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crt_pkg::StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  crt_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .list_i        (step_list),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // An unterminated-quote error is always followed by a record end from the
  // same byte, so it can never be the last result of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == crt_pkg::KIND_ERROR) |-> !m_axis_tlast)
    else $error("error result marked as last of run");

  // An end-of-stream marker returns the tokenizer to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_eos_q |=> (state_q == crt_pkg::StateReset))
    else $error("state not cleared after end of stream");

  // Bytes are only held back inside a quoted field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held_valid |-> state_q.quoted)
    else $error("held byte outside a quoted field");

endmodule
